// ----- rtl/core/swhc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swhc_pkg
// Shared types and constants of the sliding window hit counter: controller
// states, the command and status words between controller and datapath.
// ----------------------------------------------------------------------------
package swhc_pkg;

	localparam int STAMP_W = 31;
	localparam int COUNT_W = 32;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// item function codes
	localparam logic FUNC_HIT   = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_REREAD
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;   // capture a new word
		logic drop;   // expire the oldest bucket
		logic apply;  // record the hit or answer the query
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic expire; // oldest live bucket has aged out
	} status_t;

endpackage
`default_nettype wire

// ----- rtl/core/swhc_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swhc_ctrl
// Controller of the hit counter: accepts a word, walks the expiry of aged
// buckets one at a time, then has the datapath apply the word.
// ----------------------------------------------------------------------------
module swhc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire swhc_pkg::status_t status,
	output swhc_pkg::cmd_t         cmd,
	output logic                   busy
);
	import swhc_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_nxt = ST_CHECK;
			end
			ST_CHECK: begin
				if (status.expire) state_nxt = ST_REREAD;
				else state_nxt = ST_IDLE;
			end
			ST_REREAD: begin
				state_nxt = ST_CHECK;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_CHECK: begin
				cmd.drop  = status.expire;
				cmd.apply = !status.expire;
			end
			ST_REREAD: begin
				busy = 1'b1;
			end
			default: busy = 1'b1;
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/core/swhc_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swhc_dp
// Datapath of the hit counter: bucket ring memory, ring pointers, live
// bucket count, running total and the registered result.
// ----------------------------------------------------------------------------
module swhc_dp #(
	parameter int WINDOW = 300
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire swhc_pkg::cmd_t                 cmd,
	input  wire logic                           func,
	input  wire logic [swhc_pkg::STAMP_W-1:0]   timestamp,
	output swhc_pkg::status_t                   status,
	output logic                                done,
	output logic [swhc_pkg::COUNT_W-1:0]        hit_count
);
	import swhc_pkg::*;

	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int LIVE_W = $clog2(WINDOW + 1);
	localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(WINDOW - 1);
	localparam logic [LIVE_W-1:0]  FULL_LIVE = LIVE_W'(WINDOW);
	localparam logic [STAMP_W-1:0] AGE_LIMIT = STAMP_W'(WINDOW);

	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
		return (s == LAST_SLOT) ? '0 : s + SLOT_W'(1);
	endfunction

	// bucket ring
	logic [STAMP_W-1:0] stamp_mem [WINDOW];
	logic [COUNT_W-1:0] hits_mem  [WINDOW];

	logic               func_q;
	logic [STAMP_W-1:0] ts_q;
	logic [SLOT_W-1:0]  oldest_q;
	logic [SLOT_W-1:0]  newest_q;
	logic [LIVE_W-1:0]  live_q;
	logic [COUNT_W-1:0] total_q;
	logic [STAMP_W-1:0] new_stamp_q;
	logic [COUNT_W-1:0] new_hits_q;
	logic [STAMP_W-1:0] rd_stamp_q;
	logic [COUNT_W-1:0] rd_hits_q;
	logic               done_q;
	logic [COUNT_W-1:0] hit_count_q;

	logic               wr_en;
	logic [SLOT_W-1:0]  wr_addr;
	logic [STAMP_W-1:0] wr_stamp;
	logic [COUNT_W-1:0] wr_hits;

	logic               match;
	logic               evict;
	logic [COUNT_W-1:0] total_sub;
	logic [SLOT_W-1:0]  oldest_a;
	logic [LIVE_W-1:0]  live_a;
	logic [COUNT_W-1:0] total_a;
	logic [COUNT_W-1:0] total_inc;
	logic [SLOT_W-1:0]  newest_a;
	logic [COUNT_W-1:0] hits_inc;

	// memory port: one write, registered read of the oldest bucket
	always_ff @(posedge clk) begin
		if (wr_en) begin
			stamp_mem[wr_addr] <= wr_stamp;
			hits_mem[wr_addr]  <= wr_hits;
		end
		rd_stamp_q <= stamp_mem[oldest_q];
		rd_hits_q  <= hits_mem[oldest_q];
	end

	// expiry test on the oldest bucket
	assign status.expire = (live_q != '0) && (ts_q >= rd_stamp_q) &&
		((ts_q - rd_stamp_q) >= AGE_LIMIT);

	// total after removing the oldest bucket, clamped at zero
	assign total_sub = (total_q >= rd_hits_q) ? total_q - rd_hits_q : '0;

	// hit handling: same second, or open a new bucket
	always_comb begin
		match     = (live_q != '0) && (new_stamp_q == ts_q);
		evict     = (live_q == FULL_LIVE);
		oldest_a  = evict ? next_slot(oldest_q) : oldest_q;
		live_a    = evict ? live_q - LIVE_W'(1) : live_q;
		total_a   = evict ? total_sub : total_q;
		total_inc = (total_a == COUNT_MAX) ? total_a : total_a + COUNT_W'(1);
		newest_a  = (live_a == '0) ? oldest_a : next_slot(newest_q);
		hits_inc  = (new_hits_q == COUNT_MAX) ? new_hits_q : new_hits_q + COUNT_W'(1);
		wr_en     = cmd.apply && (func_q == FUNC_HIT);
		wr_addr   = match ? newest_q : newest_a;
		wr_stamp  = ts_q;
		wr_hits   = match ? hits_inc : COUNT_W'(1);
	end

	// ring control and total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			newest_q <= '0;
			live_q   <= '0;
			total_q  <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= cmd.apply && (func_q == FUNC_QUERY);
			if (cmd.drop) begin
				total_q  <= total_sub;
				oldest_q <= next_slot(oldest_q);
				live_q   <= live_q - LIVE_W'(1);
			end else if (wr_en) begin
				if (match) begin
					total_q <= (total_q == COUNT_MAX) ? total_q : total_q + COUNT_W'(1);
				end else begin
					total_q  <= total_inc;
					oldest_q <= oldest_a;
					newest_q <= newest_a;
					live_q   <= live_a + LIVE_W'(1);
				end
			end
		end
	end

	// word capture, newest bucket copy and result
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			ts_q   <= timestamp;
		end
		if (wr_en) begin
			new_stamp_q <= wr_stamp;
			new_hits_q  <= wr_hits;
		end
		if (cmd.apply) begin
			hit_count_q <= total_q;
		end
	end

	assign done      = done_q;
	assign hit_count = hit_count_q;

endmodule
`default_nettype wire

// ----- rtl/core/sliding_window_hit_counter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_hit_counter
// Counts hits per second in a ring of buckets and answers queries with the
// number of hits seen in the last WINDOW seconds.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; func selects a hit (0)
// or a query (1) at the given timestamp. A query answers with hit_count on
// the cycle that done is high, one cycle only: the receiver cannot stall, so
// it must take the result then. A word is loaded in idle and then checked;
// every aged bucket it expires adds a drop and a reread before the next check,
// since the bucket memory has one registered read port on the oldest bucket
// and each expiry needs a fresh read. Each bucket expires once and only a hit
// opens one, so over a long run a word expires at most one bucket on average,
// fewer when hits share seconds. The memory needs no clearing after reset.
// ----------------------------------------------------------------------------
module sliding_window_hit_counter #(
	parameter int WINDOW = 300
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic                         func,
	input  wire logic [swhc_pkg::STAMP_W-1:0] timestamp,
	output logic                              done,
	output logic [swhc_pkg::COUNT_W-1:0]      hit_count
);
	import swhc_pkg::*;

	cmd_t    cmd;
	status_t status;

	// sequencing
	swhc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// bucket ring and totals
	swhc_dp #(
		.WINDOW (WINDOW)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.func      (func),
		.timestamp (timestamp),
		.status    (status),
		.done      (done),
		.hit_count (hit_count)
	);

endmodule
`default_nettype wire

// ----- rtl/core/swhc_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swhc_checker
// Port level checks of the hit counter sequencing, bound to the top level.
// ----------------------------------------------------------------------------
module swhc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done
);

	// busy is raised right after an accepted word
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accepted word");

	// a result only follows a busy cycle
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without preceding work");

	// a result comes out as the block returns to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result while still busy");

	// results never come in consecutive cycles
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

endmodule

bind sliding_window_hit_counter swhc_checker u_swhc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);
`default_nettype wire
